FILE: rtl/divisor_sum_sigma_macros.svh
// Assertion macros for the divisor-sum block.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef DIVISOR_SUM_SIGMA_MACROS_SVH
`define DIVISOR_SUM_SIGMA_MACROS_SVH
// Same-cycle implication, disabled while reset is high.
`define DSS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("divisor sum assertion failed");
// Next-cycle implication, disabled while reset is high.
`define DSS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("divisor sum assertion failed");
`endif

FILE: rtl/dss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the build-time prime bound for the divisor-sum block.
// No dependencies.
package dss_pkg;

   localparam int VALUE_BITS_DEF  = 17;
   localparam int PRIME_COUNT_DEF = 72;
   localparam int N_VALUE_BITS    = 17;
   localparam int SIGMA_BITS      = 20;
   localparam logic [SIGMA_BITS-1:0] SIGMA_MAX = 20'hFFFFF;

   // The sieve covers the largest prime table allowed; the 1024th prime is 8161.
   localparam int SIEVE_SIZE = 8192;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_POWER,
      ST_FOLD,
      ST_NEXT,
      ST_FINAL,
      ST_OUT
   } dss_state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic divide_out;
      logic accumulate;
      logic fold;
      logic advance;
      logic finish;
      logic emit;
   } dss_cmd_type;

   typedef struct packed {
      logic stop;
      logic div_busy;
      logic rem_zero;
      logic hit;
   } dss_stat_type;

   // Returns the count-th prime, evaluated only at elaboration.
   function automatic int nth_prime(input int count);
      logic [SIEVE_SIZE-1:0] comp;
      int found;
      int result;
      comp = '0;
      found = 0;
      result = 2;
      for (int i = 2; i * i < SIEVE_SIZE; i++) begin
         if (!comp[i]) begin
            for (int j = i * i; j < SIEVE_SIZE; j += i) begin
               comp[j] = 1'b1;
            end
         end
      end
      for (int k = 2; k < SIEVE_SIZE; k++) begin
         if (!comp[k] && found < count) begin
            found++;
            result = k;
         end
      end
      return result;
   endfunction

endpackage

FILE: rtl/dss_div.sv
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle.
// Depends on dss_pkg.
module dss_div
   import dss_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int DIV_BITS   = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0]   divisor,
   output logic                  busy,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [DIV_BITS-1:0]   remainder
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_BITS:0]     shifted;
   logic [DIV_BITS:0]     diff;
   logic                  ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[VALUE_BITS-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         cnt_in = CNT_BITS'(VALUE_BITS);
         quo_in = dividend;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[VALUE_BITS-2:0], ge};
         rem_in = ge ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/dss_datapath.sv
`timescale 1ns / 1ps
// Datapath: cofactor, trial divisor, geometric sum, running product and result registers.
// Depends on dss_pkg and dss_div.
module dss_datapath
   import dss_pkg::*;
#(
   parameter int VALUE_BITS  = VALUE_BITS_DEF,
   parameter int PRIME_COUNT = PRIME_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [N_VALUE_BITS-1:0] req_n_value,
   input  dss_cmd_type             cmd,
   output dss_stat_type            stat,
   output logic [SIGMA_BITS-1:0]   rsp_sigma,
   output logic                    rsp_abundant
);

   localparam int PRIME_LAST = nth_prime(PRIME_COUNT);
   localparam int CAND_BITS  = $clog2(PRIME_LAST + 5);
   localparam int TOTAL_BITS = VALUE_BITS + 3;
   localparam int GEO_BITS   = VALUE_BITS + 1;
   localparam int SAT_BITS   = TOTAL_BITS + SIGMA_BITS;

   logic [VALUE_BITS-1:0] n_ff, n_in;
   logic [VALUE_BITS-1:0] m_ff, m_in;
   logic [CAND_BITS-1:0]  d_ff, d_in;
   logic                  step4_ff, step4_in;
   logic [VALUE_BITS-1:0] pw_ff, pw_in;
   logic [GEO_BITS-1:0]   geo_ff, geo_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [SIGMA_BITS-1:0] sigma_ff, sigma_in;
   logic                  abundant_ff, abundant_in;

   logic [VALUE_BITS+N_VALUE_BITS-1:0] n_wide;
   logic [2*CAND_BITS-1:0]             dsq;
   logic [VALUE_BITS+CAND_BITS-1:0]    pw_prod;
   logic [TOTAL_BITS+GEO_BITS-1:0]     geo_prod;
   logic [GEO_BITS-1:0]                m_plus;
   logic [TOTAL_BITS+GEO_BITS-1:0]     co_prod;
   logic [SAT_BITS-1:0]                total_ext;
   logic                               saturate;
   logic                               div_busy;
   logic [VALUE_BITS-1:0]              quotient;
   logic [CAND_BITS-1:0]               remainder;

   dss_div #(
      .VALUE_BITS (VALUE_BITS),
      .DIV_BITS   (CAND_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (m_ff),
      .divisor   (d_ff),
      .busy      (div_busy),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_comb begin
      n_wide    = {{VALUE_BITS{1'b0}}, req_n_value};
      dsq       = {{CAND_BITS{1'b0}}, d_ff} * {{CAND_BITS{1'b0}}, d_ff};
      pw_prod   = {{CAND_BITS{1'b0}}, pw_ff} * {{VALUE_BITS{1'b0}}, d_ff};
      geo_prod  = {{GEO_BITS{1'b0}}, total_ff} * {{TOTAL_BITS{1'b0}}, geo_ff};
      m_plus    = {1'b0, m_ff} + GEO_BITS'(1);
      co_prod   = {{GEO_BITS{1'b0}}, total_ff} * {{TOTAL_BITS{1'b0}}, m_plus};
      total_ext = {{SIGMA_BITS{1'b0}}, total_ff};
      saturate  = total_ext > {{TOTAL_BITS{1'b0}}, SIGMA_MAX};

      stat.stop     = ({{VALUE_BITS{1'b0}}, dsq} > {{(2 * CAND_BITS){1'b0}}, m_ff})
                      || (d_ff > CAND_BITS'(PRIME_LAST));
      stat.div_busy = div_busy;
      stat.rem_zero = remainder == '0;
      stat.hit      = geo_ff != GEO_BITS'(1);
   end

   always_comb begin
      n_in        = n_ff;
      m_in        = m_ff;
      d_in        = d_ff;
      step4_in    = step4_ff;
      pw_in       = pw_ff;
      geo_in      = geo_ff;
      total_in    = total_ff;
      sigma_in    = sigma_ff;
      abundant_in = abundant_ff;
      if (cmd.load) begin
         n_in     = n_wide[VALUE_BITS-1:0];
         m_in     = n_wide[VALUE_BITS-1:0];
         d_in     = CAND_BITS'(2);
         step4_in = 1'b0;
         pw_in    = VALUE_BITS'(1);
         geo_in   = GEO_BITS'(1);
         total_in = TOTAL_BITS'(1);
      end
      if (cmd.divide_out) begin
         m_in  = quotient;
         pw_in = pw_prod[VALUE_BITS-1:0];
      end
      if (cmd.accumulate) begin
         geo_in = geo_ff + {1'b0, pw_ff};
      end
      if (cmd.fold) begin
         total_in = geo_prod[TOTAL_BITS-1:0];
      end
      if (cmd.advance) begin
         pw_in  = VALUE_BITS'(1);
         geo_in = GEO_BITS'(1);
         if (d_ff == CAND_BITS'(2)) begin
            d_in = CAND_BITS'(3);
         end else if (d_ff == CAND_BITS'(3)) begin
            d_in     = CAND_BITS'(5);
            step4_in = 1'b0;
         end else begin
            d_in     = d_ff + (step4_ff ? CAND_BITS'(4) : CAND_BITS'(2));
            step4_in = !step4_ff;
         end
      end
      if (cmd.finish) begin
         if (n_ff == '0) begin
            total_in = '0;
         end else if (m_ff > VALUE_BITS'(1)) begin
            total_in = co_prod[TOTAL_BITS-1:0];
         end
      end
      if (cmd.emit) begin
         sigma_in    = saturate ? SIGMA_MAX : total_ext[SIGMA_BITS-1:0];
         abundant_in = total_ff > {2'b00, n_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      m_ff        <= m_in;
      d_ff        <= d_in;
      step4_ff    <= step4_in;
      pw_ff       <= pw_in;
      geo_ff      <= geo_in;
      total_ff    <= total_in;
      sigma_ff    <= sigma_in;
      abundant_ff <= abundant_in;
   end

   assign rsp_sigma    = sigma_ff;
   assign rsp_abundant = abundant_ff;

endmodule

FILE: rtl/dss_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences trial division and owns both handshakes.
// Depends on dss_pkg and divisor_sum_sigma_macros.svh.
`include "divisor_sum_sigma_macros.svh"
module dss_ctrl
   import dss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dss_stat_type stat,
   output dss_cmd_type  cmd
);

   dss_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stat.stop ? ST_FINAL : ST_DIV;
         end
         ST_DIV: begin
            if (!stat.div_busy) begin
               if (stat.rem_zero) begin
                  state_in = ST_POWER;
               end else if (stat.hit) begin
                  state_in = ST_FOLD;
               end else begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_POWER: state_in = ST_DIV;
         ST_FOLD:  state_in = ST_NEXT;
         ST_NEXT:  state_in = ST_CHECK;
         ST_FINAL: state_in = ST_OUT;
         ST_OUT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CHECK: cmd.div_start = !stat.stop;
         ST_DIV:   cmd.divide_out = !stat.div_busy && stat.rem_zero;
         ST_POWER: begin
            cmd.accumulate = 1'b1;
            cmd.div_start  = 1'b1;
         end
         ST_FOLD:  cmd.fold = 1'b1;
         ST_NEXT:  cmd.advance = 1'b1;
         ST_FINAL: cmd.finish = 1'b1;
         ST_OUT:   cmd.emit = slot_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `DSS_ASSERT_IMP(a_emit_slot_free, clock, reset, cmd.emit, !rsp_valid_ff || rsp_ready)
   `DSS_ASSERT_IMP(a_div_only_in_div, clock, reset, stat.div_busy, state_ff == ST_DIV)
   `DSS_ASSERT_IMP(a_divide_out_exact, clock, reset, cmd.divide_out, stat.rem_zero)
   `DSS_ASSERT_IMP(a_fold_needs_hit, clock, reset, cmd.fold, stat.hit)
   `DSS_ASSERT_NXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid_ff)

endmodule

FILE: rtl/divisor_sum_sigma.sv
`timescale 1ns / 1ps
// Top level of the divisor-sum (sigma) block: controller plus datapath.
// Depends on dss_pkg, dss_ctrl and dss_datapath.
//
//   Channel   Ports                           Direction   Beat
//   req       req_valid/ready, req_n_value    in          one n per beat
//   rsp       rsp_valid/ready, rsp_sigma,     out         one result per beat
//             rsp_abundant
//
// Trial divisors (2, 3, then 6k-1 and 6k+1) each go through the one-bit-per-cycle divider;
// each repeated prime factor adds one more division. Trial stops once the divisor squared
// exceeds the cofactor or passes the last table prime.
// Reset is synchronous and clears the controller and divider counter; no clearing pass.
// A finished result waits in the output register; the next beat is accepted meanwhile.
module divisor_sum_sigma
   import dss_pkg::*;
#(
   parameter int VALUE_BITS  = VALUE_BITS_DEF,
   parameter int PRIME_COUNT = PRIME_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [N_VALUE_BITS-1:0] req_n_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SIGMA_BITS-1:0]   rsp_sigma,
   output logic                    rsp_abundant
);

   dss_cmd_type  cmd;
   dss_stat_type stat;

   dss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dss_datapath #(
      .VALUE_BITS  (VALUE_BITS),
      .PRIME_COUNT (PRIME_COUNT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_n_value  (req_n_value),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_sigma    (rsp_sigma),
      .rsp_abundant (rsp_abundant)
   );

endmodule

FILE: bench/tb_divisor_sum_sigma.sv
`timescale 1ns / 1ps
// Self-checking testbench for divisor_sum_sigma: a table of directed values, then random
// ones, checked against table answers or a divisor-sum predictor on its own prime list.
// Depends on dss_pkg and the divisor_sum_sigma RTL.
module tb_divisor_sum_sigma
   import dss_pkg::*;
();

   localparam int VALUE_BITS  = VALUE_BITS_DEF;
   localparam int PRIME_COUNT = PRIME_COUNT_DEF;
   localparam longint unsigned N_MAX = (64'd1 << N_VALUE_BITS) - 1;
   localparam int RANDOM_COUNT = 300;
   localparam int DRAIN_CYCLES = 2600;
   localparam longint CYCLE_LIMIT = 4_000_000;
   localparam int DIRECTED_COUNT = 20;

   typedef struct packed {
      logic [N_VALUE_BITS-1:0] n;
      logic                    fixed;
      logic [SIGMA_BITS-1:0]   sigma;
      logic                    abundant;
   } stim_row_type;

   typedef struct packed {
      logic [N_VALUE_BITS-1:0] n;
      logic [SIGMA_BITS-1:0]   sigma;
      logic                    abundant;
   } sigma_expect_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [N_VALUE_BITS-1:0] req_n_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [SIGMA_BITS-1:0]   rsp_sigma;
   logic                    rsp_abundant;

   logic                  row_fixed = 1'b0;
   logic [SIGMA_BITS-1:0] row_sigma = '0;
   logic                  row_abundant = 1'b0;

   longint unsigned  prime_list [PRIME_COUNT];
   sigma_expect_type pending_sums [$];
   sigma_expect_type incoming_sum;
   sigma_expect_type oldest_sum;
   bit               calm_phase = 1'b0;
   int               error_count = 0;
   longint           cycle_count = 0;

   // Zero, unity, a small prime, the largest value (a prime) and a power of two carry
   // their answers; the rest go through the predictor.
   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{17'd0,      1'b1, 20'd0,      1'b0},
      '{17'd1,      1'b1, 20'd1,      1'b0},
      '{17'd2,      1'b1, 20'd3,      1'b0},
      '{17'd131071, 1'b1, 20'd131072, 1'b0},
      '{17'd65536,  1'b1, 20'd131071, 1'b0},
      '{17'd4,      1'b0, 20'd0,      1'b0},
      '{17'd6,      1'b0, 20'd0,      1'b0},
      '{17'd12,     1'b0, 20'd0,      1'b0},
      '{17'd28,     1'b0, 20'd0,      1'b0},
      '{17'd945,    1'b0, 20'd0,      1'b0},
      '{17'd43690,  1'b0, 20'd0,      1'b0},
      '{17'd87381,  1'b0, 20'd0,      1'b0},
      '{17'd128881, 1'b0, 20'd0,      1'b0},
      '{17'd126727, 1'b0, 20'd0,      1'b0},
      '{17'd130321, 1'b0, 20'd0,      1'b0},
      '{17'd83160,  1'b0, 20'd0,      1'b0},
      '{17'd110880, 1'b0, 20'd0,      1'b0},
      '{17'd65537,  1'b0, 20'd0,      1'b0},
      '{17'd131070, 1'b0, 20'd0,      1'b0},
      '{17'd1024,   1'b0, 20'd0,      1'b0}
   };

   divisor_sum_sigma #(
      .VALUE_BITS  (VALUE_BITS),
      .PRIME_COUNT (PRIME_COUNT)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_n_value  (req_n_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_sigma    (rsp_sigma),
      .rsp_abundant (rsp_abundant)
   );

   always #5 clock = ~clock;

   function automatic void build_prime_list();
      longint unsigned cand;
      int found;
      bit is_prime;
      cand = 2;
      found = 0;
      while (found < PRIME_COUNT) begin
         is_prime = 1'b1;
         for (int k = 0; k < found; k++) begin
            if (prime_list[k] * prime_list[k] > cand) break;
            if (cand % prime_list[k] == 0) begin
               is_prime = 1'b0;
               break;
            end
         end
         if (is_prime) begin
            prime_list[found] = cand;
            found++;
         end
         cand++;
      end
   endfunction

   function automatic sigma_expect_type predict_divisor_sum(
      input logic [N_VALUE_BITS-1:0] n_in);
      sigma_expect_type sum;
      longint unsigned  n;
      longint unsigned  rest;
      longint unsigned  total;
      longint unsigned  pw;
      longint unsigned  geo;
      longint unsigned  p;
      n = longint'(n_in) & ((64'd1 << VALUE_BITS) - 1);
      sum.n = n_in;
      if (n == 0) begin
         sum.sigma = '0;
         sum.abundant = 1'b0;
         return sum;
      end
      rest = n;
      total = 1;
      for (int i = 0; i < PRIME_COUNT; i++) begin
         p = prime_list[i];
         if (p * p > rest) break;
         if (rest % p == 0) begin
            pw = 1;
            geo = 1;
            while (rest % p == 0) begin
               rest = rest / p;
               pw = pw * p;
               geo = geo + pw;
            end
            total = total * geo;
         end
      end
      if (rest > 1) total = total * (rest + 1);
      sum.sigma = (total > longint'(SIGMA_MAX)) ? SIGMA_MAX : total[SIGMA_BITS-1:0];
      sum.abundant = (total > 2 * n);
      return sum;
   endfunction

   function automatic logic [N_VALUE_BITS-1:0] pick_n_value();
      int unsigned     mode;
      longint unsigned prod;
      longint unsigned p;
      mode = $urandom_range(0, 99);
      if (mode < 45) return N_VALUE_BITS'($urandom_range(1, 1023));
      if (mode < 70) return N_VALUE_BITS'($urandom_range(0, int'(N_MAX)));
      if (mode < 85) begin
         prod = 1;
         repeat ($urandom_range(1, 12)) begin
            p = prime_list[$urandom_range(0, 9)];
            if (prod * p <= N_MAX) prod = prod * p;
         end
         return prod[N_VALUE_BITS-1:0];
      end
      prod = prime_list[$urandom_range(0, PRIME_COUNT - 1)]
           * prime_list[$urandom_range(PRIME_COUNT - 12, PRIME_COUNT - 1)];
      return prod[N_VALUE_BITS-1:0];
   endfunction

   function automatic int draw_idle();
      return calm_phase ? 0 : int'($urandom_range(0, 17));
   endfunction

   task automatic send_n_value(input logic [N_VALUE_BITS-1:0] n, input stim_row_type row);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_n_value  <= n;
      row_fixed    <= row.fixed;
      row_sigma    <= row.sigma;
      row_abundant <= row.abundant;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      build_prime_list();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_n_value(directed_rows[i].n, directed_rows[i]);
      end
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         calm_phase = ((i / 40) % 3 == 1);
         send_n_value(pick_n_value(), '0);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_idle();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            incoming_sum = predict_divisor_sum(req_n_value);
            if (row_fixed) begin
               incoming_sum.sigma = row_sigma;
               incoming_sum.abundant = row_abundant;
            end
            pending_sums.push_back(incoming_sum);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_sums.size() == 0) begin
               $error("result beat with no value outstanding: sigma %0d", rsp_sigma);
               error_count++;
            end else begin
               oldest_sum = pending_sums.pop_front();
               if (rsp_sigma !== oldest_sum.sigma) begin
                  $error("sigma for n=%0d: expected %0d, actual %0d",
                         oldest_sum.n, oldest_sum.sigma, rsp_sigma);
                  error_count++;
               end
               if (rsp_abundant !== oldest_sum.abundant) begin
                  $error("abundant for n=%0d: expected %0d, actual %0d",
                         oldest_sum.n, oldest_sum.abundant, rsp_abundant);
                  error_count++;
               end
            end
         end
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
